@@ rtl/core/ils_pkg.sv @@
package ils_pkg;

  // payload widths
  localparam int OP_W    = 3;
  localparam int POS_W   = 9;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 9;

  // operation codes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

@@ rtl/core/ils_if.sv @@
interface ils_req_if;
  import ils_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value_in;

  modport source (output valid, output operation, output position, output value_in,
                  input ready);
  modport sink (input valid, input operation, input position, input value_in,
                output ready);
endinterface

interface ils_rsp_if;
  import ils_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [COUNT_W-1:0]      item_count;

  modport source (output valid, output read_value, output status, output item_count,
                  input ready);
  modport sink (input valid, input read_value, input status, input item_count,
                output ready);
endinterface

@@ rtl/core/ils_ram.sv @@
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ils_ctrl.sv @@
module ils_ctrl #(
  parameter int CAPACITY = 256,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  ils_req_if.sink                     req,
  ils_rsp_if.source                   rsp,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [ils_pkg::VAL_W-1:0]   mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [ils_pkg::VAL_W-1:0]   mem_rdata
);
  import ils_pkg::*;

  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_WAIT, S_INS, S_INS_LAST, S_REM_HEAD, S_REM, S_FIN
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    pos_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] res_value;
  logic [ST_W-1:0]  res_status;

  logic            accept;
  logic [XW-1:0]   pos_x;
  logic [XW-1:0]   cnt_x;
  logic            pos_lt;
  logic            pos_le;
  logic            full;
  logic            more_rem;
  logic [ST_W-1:0] res_status_next;
  state_t          accept_state;
  logic            grow_now;
  logic            rsp_load;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign pos_x     = XW'(req.position);
  assign cnt_x     = XW'(cnt);
  assign pos_lt    = pos_x < cnt_x;
  assign pos_le    = pos_x <= cnt_x;
  assign full      = (cnt == CW'(CAPACITY));
  // another entry above rd_ptr still to move down
  assign more_rem  = (CW'(rd_ptr) + CW'(1)) < cnt;
  assign rsp_load  = (state == S_FIN) && (!rsp.valid || rsp.ready);

  // decode of the request seen in idle
  always_comb begin
    res_status_next = ST_OK;
    accept_state    = S_FIN;
    case (req.operation)
      OP_READ: begin
        if (pos_lt) begin
          accept_state = S_RD_WAIT;
        end else begin
          res_status_next = ST_RANGE;
        end
      end
      OP_WRITE: begin
        if (!pos_lt) begin
          res_status_next = ST_RANGE;
        end
      end
      OP_APPEND: begin
        if (full) begin
          res_status_next = ST_FULL;
        end
      end
      OP_INSERT: begin
        if (full) begin
          res_status_next = ST_FULL;
        end else if (!pos_le) begin
          res_status_next = ST_RANGE;
        end else if (pos_x != cnt_x) begin
          accept_state = S_INS;
        end
      end
      OP_REMOVE: begin
        if (pos_lt) begin
          accept_state = S_REM_HEAD;
        end else begin
          res_status_next = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // append, or insert at the end, finishes in one write
  assign grow_now = (res_status_next == ST_OK) && (accept_state == S_FIN) &&
                    ((req.operation == OP_APPEND) || (req.operation == OP_INSERT));

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = mem_rdata;
    mem_raddr = rd_ptr + AW'(1);
    case (state)
      S_IDLE: begin
        mem_raddr = AW'(pos_x);
        if (accept) begin
          case (req.operation)
            OP_WRITE: begin
              mem_we    = pos_lt;
              mem_waddr = AW'(pos_x);
              mem_wdata = req.value_in;
            end
            OP_APPEND: begin
              mem_we    = !full;
              mem_waddr = AW'(cnt);
              mem_wdata = req.value_in;
            end
            OP_INSERT: begin
              // insert at the end needs no shift
              mem_we    = !full && (pos_x == cnt_x);
              mem_waddr = AW'(pos_x);
              mem_wdata = req.value_in;
              mem_raddr = AW'(cnt - CW'(1));
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_raddr = rd_ptr - AW'(1);
      end
      S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
      end
      S_REM: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_value  <= '0;
            res_status <= res_status_next;
            pos_r      <= AW'(pos_x);
            val_r      <= req.value_in;
            state      <= accept_state;
            if (accept_state == S_INS) begin
              rd_ptr  <= AW'(cnt - CW'(1));
              wr_addr <= AW'(cnt);
            end else begin
              rd_ptr <= AW'(pos_x);
            end
            if (grow_now) begin
              cnt <= cnt + CW'(1);
            end
          end
        end
        S_RD_WAIT: begin
          res_value <= mem_rdata;
          state     <= S_FIN;
        end
        S_INS: begin
          // entry at rd_ptr is being moved up this cycle
          if (rd_ptr > pos_r) begin
            wr_addr <= rd_ptr;
            rd_ptr  <= rd_ptr - AW'(1);
          end else begin
            state <= S_INS_LAST;
          end
        end
        S_INS_LAST: begin
          cnt   <= cnt + CW'(1);
          state <= S_FIN;
        end
        S_REM_HEAD: begin
          res_value <= mem_rdata;
          if (more_rem) begin
            wr_addr <= rd_ptr;
            rd_ptr  <= rd_ptr + AW'(1);
            state   <= S_REM;
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_FIN;
          end
        end
        S_REM: begin
          if (more_rem) begin
            wr_addr <= rd_ptr;
            rd_ptr  <= rd_ptr + AW'(1);
          end else begin
            cnt   <= cnt - CW'(1);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (rsp_load) begin
            rsp.read_value <= res_value;
            rsp.status     <= res_status;
            rsp.item_count <= COUNT_W'(cnt);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("item count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt == $past(cnt)) || (cnt == $past(cnt) + CW'(1)) ||
                    (cnt + CW'(1) == $past(cnt)))
    else $error("item count moved by more than one");

  a_ins_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (rd_ptr >= pos_r) &&
                         (CW'(wr_addr) == CW'(rd_ptr) + CW'(1)))
    else $error("insert shift addresses out of order");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_status == ST_FULL) |-> full)
    else $error("full status while store not full");

endmodule

@@ rtl/core/indexed_list_store_top.sv @@
// Ordered list of signed 32-bit values held in one CAPACITY-entry memory (one write and
// one registered read port) plus an item count. Requests take read, write, append,
// insert or remove; every request gives exactly one response with the value read or
// removed, a status (ok, full, out of range) and the item count afterward. One request
// is worked at a time. Write, append, insert at the end and any rejected request go from
// idle straight to the response state, and read first waits for the registered read. Any
// other insert and any remove shift the later entries, one entry per cycle through the
// single memory port pair, so they take longer the more entries lie past the position.
// The next request is taken while a response still waits to be transferred. No clearing
// pass is needed after reset.
module indexed_list_store_top #(
  parameter int CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);
  import ils_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  ils_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ils_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
